[rtl/ulscp_pkg.sv]
`default_nettype none

package ulscp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int STEP_W = 3;

    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_W = 8'h77;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'h57;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic KIND_TX = 1'b0;
    localparam logic KIND_LED = 1'b1;

    typedef enum logic [2:0] {
        OP_ECHO    = 3'd0,
        OP_UNKNOWN = 3'd1,
        OP_LED_CMD = 3'd2,
        OP_SWT     = 3'd3,
        OP_LED_WR  = 3'd4
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] echo;
        logic [7:0] value;
    } job_t;

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = b - CH_ZERO;
        end else if (b >= CH_A && b <= CH_F) begin
            d = b - HEX_ALPHA_OFS;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        return (v <= 4'd9) ? (w + CH_ZERO) : (w + HEX_ALPHA_OFS);
    endfunction

endpackage

`default_nettype wire

[rtl/uart_led_switch_command_parser_unit.sv]
// A byte accepted on s_ is written into the job queue; its first word is then registered
// from the queue head into the m_ output registers. One byte per cycle goes into the job
// queue while it has room; the back end emits one word per cycle while m_ready is high.
// Null letter bytes are absorbed without a word. A full queue holds s_ready low.
// Reset (aresetn low, synchronous) returns to awaiting the first letter, empties the queue.
`default_nettype none

module uart_led_switch_command_parser_unit
    import ulscp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic [7:0] s_switch_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_result_kind,
    output logic [7:0]      m_result_value,
    output logic            m_last
);

    logic q_full, q_push, q_pop, q_not_empty;
    job_t push_job, head_job;

    ulscp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_switch_value (s_switch_value),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    ulscp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    ulscp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (q_not_empty),
        .job            (head_job),
        .job_pop        (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_result_value (m_result_value),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

[rtl/ulscp_front.sv]
`default_nettype none

module ulscp_front
    import ulscp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic [7:0] s_switch_value,
    input  wire logic       q_full,
    output logic            q_push,
    output job_t            q_job
);

    typedef enum logic [4:0] {
        PH_FIRST  = 5'b00001,
        PH_SECOND = 5'b00010,
        PH_THIRD  = 5'b00100,
        PH_DIG_HI = 5'b01000,
        PH_DIG_LO = 5'b10000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] first_letter_reg, first_letter_next;
    logic [7:0] second_letter_reg, second_letter_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       accept;
    logic       produce;
    logic       is_null;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_null = (s_rx_byte == 8'h00);
    assign q_push  = accept && produce;

    always_comb begin
        phase_next         = phase_reg;
        first_letter_next  = first_letter_reg;
        second_letter_next = second_letter_reg;
        high_nibble_next   = high_nibble_reg;
        produce            = 1'b0;
        q_job.op           = OP_ECHO;
        q_job.echo         = s_rx_byte;
        q_job.value        = s_switch_value;
        unique case (phase_reg)
            PH_SECOND: begin
                if (!is_null) begin
                    produce            = 1'b1;
                    second_letter_next = s_rx_byte;
                    phase_next         = PH_THIRD;
                end
            end
            PH_THIRD: begin
                if (!is_null) begin
                    produce = 1'b1;
                    if (first_letter_reg == CH_L && second_letter_reg == CH_E
                        && s_rx_byte == CH_D) begin
                        q_job.op   = OP_LED_CMD;
                        phase_next = PH_DIG_HI;
                    end else if (first_letter_reg == CH_S && second_letter_reg == CH_W
                        && s_rx_byte == CH_T) begin
                        q_job.op   = OP_SWT;
                        phase_next = PH_FIRST;
                    end else begin
                        q_job.op   = OP_UNKNOWN;
                        phase_next = PH_FIRST;
                    end
                end
            end
            PH_DIG_HI: begin
                produce          = 1'b1;
                high_nibble_next = hex_value(s_rx_byte);
                phase_next       = PH_DIG_LO;
            end
            PH_DIG_LO: begin
                produce     = 1'b1;
                q_job.op    = OP_LED_WR;
                q_job.value = {high_nibble_reg, hex_value(s_rx_byte)};
                phase_next  = PH_FIRST;
            end
            default: begin
                if (!is_null) begin
                    produce           = 1'b1;
                    first_letter_next = s_rx_byte;
                    phase_next        = PH_SECOND;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_FIRST;
            first_letter_reg  <= 8'h00;
            second_letter_reg <= 8'h00;
            high_nibble_reg   <= 4'h0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            first_letter_reg  <= first_letter_next;
            second_letter_reg <= second_letter_next;
            high_nibble_reg   <= high_nibble_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ulscp_queue.sv]
`default_nettype none

module ulscp_queue
    import ulscp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

[rtl/ulscp_back.sv]
`default_nettype none

module ulscp_back
    import ulscp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic job_valid,
    input  wire job_t job,
    output logic      job_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic      m_result_kind,
    output logic [7:0] m_result_value,
    output logic      m_last
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] last_step;
    logic              m_valid_reg;
    logic              kind_reg;
    logic [7:0]        value_reg;
    logic              last_reg;
    logic              load;
    logic              is_last;
    logic              item_kind;
    logic [7:0]        item_value;

    assign load    = job_valid && (!m_valid_reg || m_ready);
    assign is_last = (step_reg == last_step);
    assign job_pop = load && is_last;

    always_comb begin
        item_kind  = KIND_TX;
        item_value = job.echo;
        last_step  = STEP_W'(0);
        case (job.op)
            OP_UNKNOWN: begin
                last_step = STEP_W'(3);
                case (step_reg)
                    STEP_W'(1): item_value = CH_SPACE;
                    STEP_W'(2): item_value = CH_LF;
                    STEP_W'(3): item_value = CH_CR;
                    default:    item_value = job.echo;
                endcase
            end
            OP_LED_CMD: begin
                last_step = STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    item_value = CH_SPACE;
                end
            end
            OP_SWT: begin
                last_step = STEP_W'(5);
                case (step_reg)
                    STEP_W'(1): item_value = CH_SPACE;
                    STEP_W'(2): item_value = hex_char(job.value[7:4]);
                    STEP_W'(3): item_value = hex_char(job.value[3:0]);
                    STEP_W'(4): item_value = CH_LF;
                    STEP_W'(5): item_value = CH_CR;
                    default:    item_value = job.echo;
                endcase
            end
            OP_LED_WR: begin
                last_step = STEP_W'(3);
                case (step_reg)
                    STEP_W'(1): begin
                        item_kind  = KIND_LED;
                        item_value = job.value;
                    end
                    STEP_W'(2): item_value = CH_LF;
                    STEP_W'(3): item_value = CH_CR;
                    default:    item_value = job.echo;
                endcase
            end
            default: begin
                last_step = STEP_W'(0);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                step_reg    <= is_last ? '0 : step_reg + 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= item_kind;
            value_reg <= item_value;
            last_reg  <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_result_value = value_reg;
    assign m_last         = last_reg;

    a_led_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == KIND_LED |-> !last_reg)
        else $error("LED write marked as final word");

    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !job_valid |-> step_reg == '0)
        else $error("step counter busy with no job");

endmodule

`default_nettype wire
